### rtl/assert_macros.svh
// Assertion macros used by the block's top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/chm_pkg.sv
// Package for the chained hash map engine: codes, widths and command types.
// No dependencies.
package chm_pkg;
    localparam int BUCKETS_DEF = 1024;
    localparam int POOL_NODES_DEF = 256;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the input item
        logic clr_step;    // clear-sweep write of one bucket and free slot
        logic rd_head;     // read bucket entry
        logic rd_node;     // read current pool node
        logic ins_head;    // write new head
        logic ins_node;    // pop free node, link behind head
        logic rm_head_empty;
        logic rm_head_copy; // copy node into head, free node
        logic rm_node;     // unlink current node
        logic advance;     // move to next node in chain
        logic finish;      // load result register
        logic [1:0] fin_status;
        logic fin_hit_val;
    } chm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic key_zero;
        logic [1:0] action;
        logic head_empty;
        logic head_hit;
        logic head_linked;
        logic node_hit;
        logic node_linked;
        logic pool_empty;
    } chm_sts_t;
endpackage

### rtl/chm_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface chm_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/chained_hash_map_engine.sv
// Top level of the chained hash map engine: controller plus datapath.
// Depends on chm_pkg, chm_if, chm_ctrl, chm_datapath and assert_macros.svh.
// One operation at a time: an operation settled at the bucket head reads the
// head in S_HEAD and decides in S_DEC, then raises its result; key zero and
// the unused action code finish in S_HEAD with no memory read. Each pool node
// visited on a chain, and pulling the follower into the head on removal, adds
// a node read state and a decision state; the bucket and pool memories have
// one read port. After reset a clearing pass over max(BUCKETS, POOL_NODES)
// entries runs before the first item is taken. A result waits in the output
// register until taken, and no new input is taken meanwhile.
`include "assert_macros.svh"
module chained_hash_map_engine #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
    input logic clk,
    input logic rst_n,
    chm_if.sink   req,
    chm_if.source rsp
);
    chm_pkg::chm_cmd_t cmd;
    chm_pkg::chm_sts_t sts;

    chm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .out_valid(rsp.valid),
        .out_ready(rsp.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    chm_datapath #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_action (req.data.action),
        .in_key    (req.data.key),
        .in_value  (req.data.value_in),
        .res_status(rsp.data.status),
        .res_value (rsp.data.value_out),
        .res_count (rsp.data.entry_count)
    );

    `CHM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, rsp.valid, !req.ready, "accept while result pending")
    `CHM_ASSERT_IMP(a_one_write, clk, rst_n, cmd.ins_head, !cmd.ins_node && !cmd.rm_node, "two writes at once")
    `CHM_ASSERT_NEXT(a_finish_valid, clk, rst_n, cmd.finish, rsp.valid, "result not shown")
endmodule

### rtl/chm_datapath.sv
// Datapath: bucket and pool memories, free list, chain pointers, counter.
// Depends on chm_pkg.
module chm_datapath #(
    parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  chm_pkg::chm_cmd_t       cmd,
    output chm_pkg::chm_sts_t       sts,
    input  logic [1:0]              in_action,
    input  logic [chm_pkg::KEY_W-1:0] in_key,
    input  logic [chm_pkg::VAL_W-1:0] in_value,
    output logic [1:0]              res_status,
    output logic [chm_pkg::VAL_W-1:0] res_value,
    output logic [chm_pkg::CNT_W-1:0] res_count
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int LW = $clog2(POOL_NODES + 1);     // link: 0 none, n+1 node n
    localparam int FW = $clog2(POOL_NODES + 1);     // free count
    localparam int SW = (BUCKETS > POOL_NODES) ? BW : NW;
    localparam int KW = chm_pkg::KEY_W;
    localparam int VW = chm_pkg::VAL_W;

    logic [KW-1:0] bkt_key [BUCKETS];
    logic [VW-1:0] bkt_val [BUCKETS];
    logic [LW-1:0] bkt_lnk [BUCKETS];
    logic [KW-1:0] pl_key [POOL_NODES];
    logic [VW-1:0] pl_val [POOL_NODES];
    logic [LW-1:0] pl_lnk [POOL_NODES];
    logic [NW-1:0] fl_mem [POOL_NODES];

    logic [1:0]    act_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] val_reg;
    logic [BW-1:0] bkt_reg;
    logic [KW-1:0] hk_reg;
    logic [VW-1:0] hv_reg;
    logic [LW-1:0] hl_reg;
    logic [KW-1:0] nk_reg;
    logic [VW-1:0] nv_reg;
    logic [LW-1:0] nl_reg;
    logic [LW-1:0] cur_reg;
    logic [LW-1:0] prev_reg;
    logic [NW-1:0] top_reg;      // free list entry at free_cnt-1
    logic [FW-1:0] free_cnt_reg;
    logic [chm_pkg::CNT_W-1:0] count_reg;
    logic [SW:0]   clr_reg;
    logic [1:0]    rs_reg;
    logic [VW-1:0] rv_reg;

    logic [BW-1:0] bkt_sel;
    logic [NW-1:0] cur_n, hl_n, fl_rd;
    logic [FW-1:0] free_dec;

    assign bkt_sel = BW'(in_key[BW:1]);
    assign cur_n = NW'(cur_reg - LW'(1));
    assign hl_n = NW'(hl_reg - LW'(1));
    assign free_dec = free_cnt_reg - FW'(1);
    assign fl_rd = NW'(free_dec);

    // free-list top (entry at free_cnt-1) is read into top_reg with each bucket head read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= in_action;
            key_reg <= in_key;
            val_reg <= in_value;
            bkt_reg <= bkt_sel;
        end
        if (cmd.rd_head)
        begin
            hk_reg <= bkt_key[bkt_reg];
            hv_reg <= bkt_val[bkt_reg];
            hl_reg <= bkt_lnk[bkt_reg];
            top_reg <= fl_mem[fl_rd];
        end
        if (cmd.rd_node)
        begin
            nk_reg <= pl_key[cur_n];
            nv_reg <= pl_val[cur_n];
            nl_reg <= pl_lnk[cur_n];
        end
        if (cmd.clr_step)
        begin
            if (clr_reg < (SW+1)'(BUCKETS))
            begin
                bkt_key[BW'(clr_reg)] <= '0;
                bkt_lnk[BW'(clr_reg)] <= '0;
            end
            if (clr_reg < (SW+1)'(POOL_NODES))
                fl_mem[NW'(clr_reg)] <= NW'(clr_reg);
        end
        if (cmd.ins_head)
        begin
            bkt_key[bkt_reg] <= key_reg;
            bkt_val[bkt_reg] <= val_reg;
            bkt_lnk[bkt_reg] <= '0;
        end
        if (cmd.ins_node)
        begin
            pl_key[top_reg] <= key_reg;
            pl_val[top_reg] <= val_reg;
            pl_lnk[top_reg] <= hl_reg;
            bkt_lnk[bkt_reg] <= LW'(top_reg) + LW'(1);
        end
        if (cmd.rm_head_empty)
        begin
            bkt_key[bkt_reg] <= '0;
            bkt_val[bkt_reg] <= '0;
            bkt_lnk[bkt_reg] <= '0;
        end
        if (cmd.rm_head_copy)
        begin
            bkt_key[bkt_reg] <= nk_reg;
            bkt_val[bkt_reg] <= nv_reg;
            bkt_lnk[bkt_reg] <= nl_reg;
            fl_mem[NW'(free_cnt_reg)] <= hl_n;
        end
        if (cmd.rm_node)
        begin
            if (prev_reg == '0)
                bkt_lnk[bkt_reg] <= nl_reg;
            else
                pl_lnk[NW'(prev_reg - LW'(1))] <= nl_reg;
            fl_mem[NW'(free_cnt_reg)] <= cur_n;
        end
        if (cmd.finish)
        begin
            rs_reg <= cmd.fin_status;
            rv_reg <= cmd.fin_hit_val ? ((cur_reg == '0) ? hv_reg : nv_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            free_cnt_reg <= FW'(POOL_NODES);
            count_reg <= '0;
            cur_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + (SW+1)'(1);
            if (cmd.rd_head)
            begin
                cur_reg <= '0;
                prev_reg <= '0;
            end
            if (cmd.ins_head || cmd.ins_node)
                count_reg <= count_reg + chm_pkg::CNT_W'(1);
            if (cmd.ins_node)
                free_cnt_reg <= free_dec;
            if (cmd.rm_head_empty || cmd.rm_head_copy || cmd.rm_node)
                count_reg <= (count_reg != '0) ? count_reg - chm_pkg::CNT_W'(1) : '0;
            if ((cmd.rm_head_copy || cmd.rm_node) && free_cnt_reg < FW'(POOL_NODES))
                free_cnt_reg <= free_cnt_reg + FW'(1);
            if (cmd.advance)
            begin
                prev_reg <= cur_reg;
                cur_reg <= (cur_reg == '0) ? hl_reg : nl_reg;
            end
        end
    end

    assign sts.clr_done = (clr_reg >= (SW+1)'(BUCKETS)) && (clr_reg >= (SW+1)'(POOL_NODES));
    assign sts.key_zero = (key_reg == '0);
    assign sts.action = act_reg;
    assign sts.head_empty = (hk_reg == '0);
    assign sts.head_hit = (hk_reg == key_reg);
    assign sts.head_linked = (hl_reg != '0);
    assign sts.node_hit = (nk_reg == key_reg);
    assign sts.node_linked = (nl_reg != '0);
    assign sts.pool_empty = (free_cnt_reg == '0);

    assign res_status = rs_reg;
    assign res_value = rv_reg;
    assign res_count = count_reg;
endmodule

### rtl/chm_ctrl.sv
// Controller: sequences clear sweep, head lookup, chain walk and updates.
// Depends on chm_pkg.
module chm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output chm_pkg::chm_cmd_t cmd,
    input  chm_pkg::chm_sts_t sts
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_NODE = 3'd4;
    localparam logic [2:0] S_NDEC = 3'd5;
    localparam logic [2:0] S_HCPY = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                if (sts.clr_done)
                    state_next = S_IDLE;
                else
                    cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (sts.key_zero || sts.action == chm_pkg::ACT_UNUSED)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = chm_pkg::ST_MISS;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_head = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.finish = 1'b1;
                cmd.fin_status = chm_pkg::ST_DONE;
                ov_next = 1'b1;
                state_next = S_IDLE;
                if (sts.action == chm_pkg::ACT_INSERT)
                begin
                    if (sts.head_empty)
                        cmd.ins_head = 1'b1;
                    else if (sts.pool_empty)
                        cmd.fin_status = chm_pkg::ST_FULL;
                    else
                        cmd.ins_node = 1'b1;
                end
                else if (sts.head_hit)
                begin
                    if (sts.action == chm_pkg::ACT_SEARCH)
                        cmd.fin_hit_val = 1'b1;
                    else if (!sts.head_linked)
                        cmd.rm_head_empty = 1'b1;
                    else
                    begin
                        // fetch the follower before copying it into the head
                        cmd.finish = 1'b0;
                        ov_next = ov_reg;
                        cmd.advance = 1'b1;
                        state_next = S_HCPY;
                    end
                end
                else if (sts.head_linked)
                begin
                    cmd.finish = 1'b0;
                    ov_next = ov_reg;
                    cmd.advance = 1'b1;
                    state_next = S_NODE;
                end
                else
                    cmd.fin_status = chm_pkg::ST_MISS;
            end
            S_HCPY:
            begin
                cmd.rd_node = 1'b1;
                state_next = S_NDEC;
            end
            S_NODE:
            begin
                cmd.rd_node = 1'b1;
                state_next = S_NDEC;
            end
            S_NDEC:
            begin
                cmd.finish = 1'b1;
                ov_next = 1'b1;
                state_next = S_IDLE;
                cmd.fin_status = chm_pkg::ST_DONE;
                if (sts.head_hit && sts.action == chm_pkg::ACT_REMOVE)
                    cmd.rm_head_copy = 1'b1;
                else if (sts.node_hit)
                begin
                    if (sts.action == chm_pkg::ACT_SEARCH)
                        cmd.fin_hit_val = 1'b1;
                    else
                        cmd.rm_node = 1'b1;
                end
                else if (sts.node_linked)
                begin
                    cmd.finish = 1'b0;
                    ov_next = ov_reg;
                    cmd.advance = 1'b1;
                    state_next = S_NODE;
                end
                else
                    cmd.fin_status = chm_pkg::ST_MISS;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end
endmodule

### bench/tb_chm_types.sv
// Transfer payload types for the chained hash map engine bench.
// Depends on chm_pkg.
`timescale 1ns / 100ps
package tb_chm_types;
    typedef struct packed {
        logic [1:0]                action;
        logic [chm_pkg::KEY_W-1:0] key;
        logic [chm_pkg::VAL_W-1:0] value_in;
    } map_req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [chm_pkg::VAL_W-1:0] value_out;
        logic [chm_pkg::CNT_W-1:0] entry_count;
    } map_rsp_t;
endpackage

### bench/tb_chained_hash_map_engine.sv
// Self-checking bench for chained_hash_map_engine: drives map operations,
// predicts each answer with a chained table of its own and checks every field.
// Depends on chm_pkg, chm_if, tb_chm_types and the engine RTL.
`timescale 1ns / 100ps
module tb_chained_hash_map_engine;
    localparam int NBUCKETS = chm_pkg::BUCKETS_DEF;
    localparam int NNODES = chm_pkg::POOL_NODES_DEF;
    localparam int STALL_LIMIT = 20000;

    class map_scoreboard;
        logic [chm_pkg::KEY_W-1:0] head_key [NBUCKETS];
        logic [chm_pkg::VAL_W-1:0] head_val [NBUCKETS];
        int                        head_link [NBUCKETS];
        logic [chm_pkg::KEY_W-1:0] node_key [NNODES];
        logic [chm_pkg::VAL_W-1:0] node_val [NNODES];
        int                        node_link [NNODES];
        int                        free_stack [NNODES];
        int                        free_top;
        int                        stored;
        tb_chm_types::map_rsp_t    answers_due [$];
        int                        errors;

        function new();
            for (int i = 0; i < NBUCKETS; i++)
            begin
                head_key[i] = '0;
                head_val[i] = '0;
                head_link[i] = 0;
            end
            for (int i = 0; i < NNODES; i++)
            begin
                node_link[i] = 0;
                free_stack[i] = i;
            end
            free_top = NNODES;
            stored = 0;
            errors = 0;
        endfunction

        function void note_request(tb_chm_types::map_req_t r);
            tb_chm_types::map_rsp_t a;
            int b;
            int prev;
            int cur;
            int n;
            a.status = chm_pkg::ST_MISS;
            a.value_out = '0;
            b = r.key[10:1];
            if (r.key != 0 && r.action != chm_pkg::ACT_UNUSED)
            begin
                if (r.action == chm_pkg::ACT_INSERT)
                begin
                    if (head_key[b] == 0)
                    begin
                        head_key[b] = r.key;
                        head_val[b] = r.value_in;
                        head_link[b] = 0;
                        stored++;
                        a.status = chm_pkg::ST_DONE;
                    end
                    else if (free_top == 0)
                        a.status = chm_pkg::ST_FULL;
                    else
                    begin
                        free_top--;
                        n = free_stack[free_top];
                        node_key[n] = r.key;
                        node_val[n] = r.value_in;
                        node_link[n] = head_link[b];
                        head_link[b] = n + 1;
                        stored++;
                        a.status = chm_pkg::ST_DONE;
                    end
                end
                else if (head_key[b] == r.key)
                begin
                    if (r.action == chm_pkg::ACT_SEARCH)
                        a.value_out = head_val[b];
                    else
                    begin
                        if (head_link[b] == 0)
                        begin
                            head_key[b] = '0;
                            head_val[b] = '0;
                        end
                        else
                        begin
                            // pull the first node up into the head
                            n = head_link[b] - 1;
                            head_key[b] = node_key[n];
                            head_val[b] = node_val[n];
                            head_link[b] = node_link[n];
                            free_stack[free_top++] = n;
                        end
                        stored--;
                    end
                    a.status = chm_pkg::ST_DONE;
                end
                else
                begin
                    prev = 0;
                    cur = head_link[b];
                    while (cur != 0)
                    begin
                        n = cur - 1;
                        if (node_key[n] == r.key)
                        begin
                            if (r.action == chm_pkg::ACT_SEARCH)
                                a.value_out = node_val[n];
                            else
                            begin
                                if (prev == 0)
                                    head_link[b] = node_link[n];
                                else
                                    node_link[prev - 1] = node_link[n];
                                free_stack[free_top++] = n;
                                stored--;
                            end
                            a.status = chm_pkg::ST_DONE;
                            break;
                        end
                        prev = cur;
                        cur = node_link[n];
                    end
                end
            end
            a.entry_count = stored[chm_pkg::CNT_W-1:0];
            answers_due.push_back(a);
        endfunction

        function void check_response(tb_chm_types::map_rsp_t r);
            tb_chm_types::map_rsp_t e;
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: status %0d value_out %h entry_count %0d",
                       r.status, r.value_out, r.entry_count);
                errors++;
                return;
            end
            e = answers_due.pop_front();
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, r.status);
                errors++;
            end
            if (r.value_out !== e.value_out)
            begin
                $error("value_out: expected %h, actual %h", e.value_out, r.value_out);
                errors++;
            end
            if (r.entry_count !== e.entry_count)
            begin
                $error("entry_count: expected %0d, actual %0d", e.entry_count, r.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_cycles = 0;
    int   ready_mode = 0;
    logic [chm_pkg::KEY_W-1:0] fill_keys [$];
    map_scoreboard sb;

    chm_if #(.payload_t(tb_chm_types::map_req_t)) req ();
    chm_if #(.payload_t(tb_chm_types::map_rsp_t)) rsp ();

    chained_hash_map_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // transfer monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                sb.note_request(req.data);
            if (rsp.valid && rsp.ready)
                sb.check_response(rsp.data);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls: a ready mode picked at random, re-picked at random moments
    always @(posedge clk)
    begin
        if (($urandom & 63) == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= 1'($urandom_range(0, 1));
            2: rsp.ready <= ($urandom_range(0, 3) == 0);
            default: rsp.ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    int burst_left;

    task automatic send(input logic [1:0] act, input logic [chm_pkg::KEY_W-1:0] k,
                        input logic [chm_pkg::VAL_W-1:0] v);
        tb_chm_types::map_req_t r;
        r.action = act;
        r.key = k;
        r.value_in = v;
        req.valid <= 1'b1;
        req.data <= r;
        do
            @(posedge clk);
        while (!req.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            // close the burst: pick the next length and, two times in three, drop valid and hold off
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [chm_pkg::KEY_W-1:0] pick_key();
        logic [chm_pkg::KEY_W-1:0] k;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 6)
            return $urandom;
        k[31:11] = 21'($urandom_range(1, 12) * 21'h0B6D5);
        case ($urandom_range(0, 5))
            0: k[10:1] = 10'd0;
            1: k[10:1] = 10'd1023;
            2: k[10:1] = 10'd17;
            3: k[10:1] = 10'd512;
            default: k[10:1] = 10'($urandom_range(100, 103));
        endcase
        k[0] = 1'($urandom_range(0, 1));
        return k;
    endfunction

    function automatic logic [1:0] pick_action(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return chm_pkg::ACT_UNUSED;
        if (r < insert_pct)
            return chm_pkg::ACT_INSERT;
        if (r < insert_pct + (100 - insert_pct) / 2)
            return chm_pkg::ACT_SEARCH;
        return chm_pkg::ACT_REMOVE;
    endfunction

    initial
    begin
        logic [chm_pkg::KEY_W-1:0] k;
        sb = new();
        rst_n = 1'b0;
        burst_left = 0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // key zero and the unused action code
        send(chm_pkg::ACT_INSERT, '0, 32'hFFFF_FFFF);
        send(chm_pkg::ACT_SEARCH, '0, '0);
        send(chm_pkg::ACT_REMOVE, '0, '0);
        send(chm_pkg::ACT_UNUSED, 32'h1234_5678, 32'h1);
        // extremes, misses and a lone head removal
        send(chm_pkg::ACT_SEARCH, 32'hFFFF_FFFF, '0);
        send(chm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(chm_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 32'h5555_5555);
        send(chm_pkg::ACT_INSERT, 32'h0000_0001, 32'h0);
        send(chm_pkg::ACT_SEARCH, 32'h0000_0001, '0);
        send(chm_pkg::ACT_REMOVE, 32'h0000_0001, '0);
        send(chm_pkg::ACT_SEARCH, 32'h0000_0001, '0);
        send(chm_pkg::ACT_REMOVE, 32'hFFFF_FFFE, '0);
        // head plus a chain of three in one bucket, then mid-chain unlink and head copy
        send(chm_pkg::ACT_INSERT, 32'hA000_0040, 32'h11);
        send(chm_pkg::ACT_INSERT, 32'hB000_0041, 32'h22);
        send(chm_pkg::ACT_INSERT, 32'hC000_0040, 32'h33);
        send(chm_pkg::ACT_INSERT, 32'hD000_0041, 32'h44);
        send(chm_pkg::ACT_SEARCH, 32'hB000_0041, '0);
        send(chm_pkg::ACT_REMOVE, 32'hC000_0040, '0);
        send(chm_pkg::ACT_REMOVE, 32'hA000_0040, '0);
        send(chm_pkg::ACT_SEARCH, 32'hD000_0041, '0);
        send(chm_pkg::ACT_SEARCH, 32'hB000_0041, '0);
        send(chm_pkg::ACT_SEARCH, 32'hE000_0040, '0);
        send(chm_pkg::ACT_REMOVE, 32'hFFFF_FFFF, '0);

        // mixed traffic on crowded buckets
        repeat (550)
            send(pick_action(45), pick_key(), $urandom);

        // drive the pool to exhaustion, then remove each fill key with probability two in three
        repeat (300)
        begin
            k = $urandom;
            k[10:1] = 10'd700;
            fill_keys.push_back(k);
            send(chm_pkg::ACT_INSERT, k, $urandom);
        end
        repeat (40)
            send(chm_pkg::ACT_SEARCH, fill_keys[$urandom_range(0, fill_keys.size() - 1)], '0);
        repeat (20)
            send(chm_pkg::ACT_INSERT, pick_key(), $urandom);
        while (fill_keys.size() > 0)
        begin
            k = fill_keys[0];
            fill_keys.delete(0);
            if ($urandom_range(0, 2) != 0)
                send(chm_pkg::ACT_REMOVE, k, '0);
        end

        repeat (600)
            send(pick_action(35), pick_key(), $urandom);

        req.valid <= 1'b0;
        while (sb.answers_due.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### chained_hash_map_engine.f
+incdir+rtl
rtl/chm_pkg.sv
rtl/chm_if.sv
rtl/chm_datapath.sv
rtl/chm_ctrl.sv
rtl/chained_hash_map_engine.sv
bench/tb_chm_types.sv
bench/tb_chained_hash_map_engine.sv
